// ===== rtl/assert_macros.svh =====
// Assertion macros used by the Life cell stencil top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define LCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/lcs_pkg.sv =====
// Types, constants and helper functions for the Life cell stencil.
package lcs_pkg;

    // 2-bit cell code kept in the line stores and the window
    typedef logic [1:0] cell_t;

    localparam cell_t CODE_OFF     = 2'd0;
    localparam cell_t CODE_LIVE    = 2'd1;
    localparam cell_t CODE_SURVIVE = 2'd2;
    localparam cell_t CODE_BORN    = 2'd3;

    localparam logic [31:0] PIX_OFF     = 32'hFFFF_FFFF;
    localparam logic [31:0] PIX_SURVIVE = 32'hFF00_0000;
    localparam logic [31:0] PIX_BORN    = 32'hFFFF_0000;

    // Configuration register indexes
    localparam logic CFG_FRAME_WIDTH  = 1'b0;
    localparam logic CFG_FRAME_HEIGHT = 1'b1;

    localparam int DIM_W          = 11;
    localparam int WIDTH_DEFAULT  = 640;
    localparam int HEIGHT_DEFAULT = 480;

    // Stream payload layout
    localparam int PIX_W      = 32;
    localparam int POS_W      = 10;
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 56;

    // Neighbor count thresholds
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] KEEP_COUNT  = 4'd2;

    function automatic cell_t pixel_code(input logic [PIX_W-1:0] p);
        cell_t code;
        if (p == PIX_OFF)
            code = CODE_OFF;
        else if (p == PIX_SURVIVE)
            code = CODE_SURVIVE;
        else if (p == PIX_BORN)
            code = CODE_BORN;
        else
            code = CODE_LIVE;
        return code;
    endfunction

    function automatic logic [PIX_W-1:0] code_pixel(input cell_t c);
        logic [PIX_W-1:0] p;
        case (c)
            CODE_SURVIVE: p = PIX_SURVIVE;
            CODE_BORN:    p = PIX_BORN;
            default:      p = PIX_OFF;
        endcase
        return p;
    endfunction

endpackage

// ===== rtl/lcs_ram.sv =====
// Simple dual-port RAM with one write port and one registered read port.
module lcs_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read returns the old contents when the same entry is written
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/life_cell_stencil.sv =====
// Top level of the Life cell stencil: one Life step over a streamed frame.
//
// Usage. Pixels enter in raster order on the s_ group, one per transfer:
// s_tdata carries the 32-bit pixel, s_tuser[0] marks the first pixel of a
// frame and restarts the row and column counters. Every pixel except 0xFFFFFFFF
// counts as live. Each cell's new value leaves on the m_ group once its
// lower-right neighbor has arrived; a pixel can release up to four results
// (last column and last row release the border cells), and m_tlast marks the
// final result released by one input pixel. m_tuser[0] flags a changed cell.
// Frame width and height are written through cfg_ while the block is idle.
// A result passes the update stage and output group registers before it is
// offered. Throughput: one pixel per cycle while m_tready is high and each
// pixel releases at most one result; pixels that end a row or lie in the last
// row send their results one at a time from the single output group register.
// The two previous rows live in one line memory (two 2-bit codes per column)
// read as a pixel is accepted, ahead of its update; a read that hits the entry
// written in the same cycle is forwarded. Reset clears the window, counters and
// stream control; the line memory needs no clearing pass. When m_tready is low
// the output group holds; an item with results then stalls and drops s_tready.
`include "assert_macros.svh"

module life_cell_stencil #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [lcs_pkg::DIM_W-1:0]       cfg_data,
    // pixel input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lcs_pkg::IN_DATA_W-1:0]   s_tdata,   // [31:0] pixel_in
    input  logic [0:0]                      s_tuser,   // [0] frame_start
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lcs_pkg::OUT_DATA_W-1:0]  m_tdata,   // [9:0] cell_row, [19:10] cell_col,
                                                       // [51:20] pixel_out, [55:52] zero
    output logic [0:0]                      m_tuser,   // [0] changed
    output logic                            m_tlast    // last_of_run
);

    localparam int CB  = $clog2(MAX_WIDTH);
    localparam int RB  = $clog2(MAX_HEIGHT);
    localparam int WCW = ($clog2(MAX_WIDTH + 1) > lcs_pkg::DIM_W) ?
                         $clog2(MAX_WIDTH + 1) : lcs_pkg::DIM_W;
    localparam int HCW = ($clog2(MAX_HEIGHT + 1) > lcs_pkg::DIM_W) ?
                         $clog2(MAX_HEIGHT + 1) : lcs_pkg::DIM_W;
    localparam logic [WCW-1:0] WIDTH_MAX = WCW'(MAX_WIDTH);
    localparam logic [HCW-1:0] HEIGHT_MAX = HCW'(MAX_HEIGHT);
    localparam logic [WCW-1:0] WIDTH_RST = (lcs_pkg::WIDTH_DEFAULT > MAX_WIDTH) ?
                                           WIDTH_MAX : WCW'(lcs_pkg::WIDTH_DEFAULT);
    localparam logic [HCW-1:0] HEIGHT_RST = (lcs_pkg::HEIGHT_DEFAULT > MAX_HEIGHT) ?
                                            HEIGHT_MAX : HCW'(lcs_pkg::HEIGHT_DEFAULT);

    // ------------------------------------------------------------------
    // Configuration: store the clamped dimensions
    // ------------------------------------------------------------------
    logic [WCW-1:0] width_reg, width_next;
    logic [HCW-1:0] height_reg, height_next;
    logic [WCW-1:0] cfg_w_ext;
    logic [HCW-1:0] cfg_h_ext;

    assign cfg_ready = 1'b1;
    assign cfg_w_ext = WCW'(cfg_data);
    assign cfg_h_ext = HCW'(cfg_data);

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                lcs_pkg::CFG_FRAME_WIDTH:
                begin
                    if (cfg_w_ext == '0)
                        width_next = WCW'(1);
                    else if (cfg_w_ext > WIDTH_MAX)
                        width_next = WIDTH_MAX;
                    else
                        width_next = cfg_w_ext;
                end
                lcs_pkg::CFG_FRAME_HEIGHT:
                begin
                    if (cfg_h_ext == '0)
                        height_next = HCW'(1);
                    else if (cfg_h_ext > HEIGHT_MAX)
                        height_next = HEIGHT_MAX;
                    else
                        height_next = cfg_h_ext;
                end
                default:
                begin
                    width_next  = width_reg;
                    height_next = height_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // ------------------------------------------------------------------
    // Accept stage: position, border decisions and line memory read
    // ------------------------------------------------------------------
    logic                  s_xfer;
    logic [CB-1:0]         col_reg, col_next;
    logic [RB-1:0]         row_reg, row_next;
    logic [CB-1:0]         cur_c;
    logic [RB-1:0]         cur_r;
    logic [WCW-1:0]        c_plus1;
    logic [HCW-1:0]        r_plus1;
    logic                  last_col, last_row;
    logic                  c_ge1, r_ge1, inner;
    logic [3:0]            res_mask;
    lcs_pkg::cell_t        cur_code;

    assign s_xfer   = s_tvalid && s_tready;
    assign cur_c    = s_tuser[0] ? '0 : col_reg;
    assign cur_r    = s_tuser[0] ? '0 : row_reg;
    assign c_plus1  = WCW'(cur_c) + WCW'(1);
    assign r_plus1  = HCW'(cur_r) + HCW'(1);
    assign last_col = (c_plus1 >= width_reg);
    assign last_row = (r_plus1 >= height_reg);
    assign c_ge1    = (cur_c != '0);
    assign r_ge1    = (cur_r != '0);
    assign inner    = (cur_r > RB'(1)) && (r_plus1 <= height_reg) &&
                      (cur_c > CB'(1)) && (c_plus1 <= width_reg);
    assign cur_code = lcs_pkg::pixel_code(s_tdata[lcs_pkg::PIX_W-1:0]);

    // result order: upper-left, upper, left, current cell
    assign res_mask = {last_row && last_col, last_row && c_ge1,
                       r_ge1 && last_col, r_ge1 && c_ge1};

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (s_xfer)
        begin
            if (last_col)
            begin
                col_next = '0;
                row_next = last_row ? '0 : RB'(r_plus1);
            end
            else
            begin
                col_next = CB'(c_plus1);
                row_next = cur_r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Update stage: window shift, Life rule, line memory write-back
    // ------------------------------------------------------------------
    logic                  b_valid_reg;
    logic [CB-1:0]         b_c_reg;
    logic [RB-1:0]         b_r_reg;
    logic [3:0]            b_mask_reg;
    logic                  b_inner_reg;
    lcs_pkg::cell_t        b_code_reg;
    logic                  fwd_reg;
    logic [3:0]            fwd_data_reg;
    logic                  b_commit;
    logic                  grp_free;
    logic                  grp_load;
    logic [3:0]            ram_rdata;
    logic [3:0]            line_word;
    logic [3:0]            wr_word;
    lcs_pkg::cell_t        win_reg [3][3];
    lcs_pkg::cell_t        up_code, mid_code;
    logic                  ctr_live;
    logic [3:0]            ncount;
    lcs_pkg::cell_t        v0_code;
    logic [3:0]            chg_bits;

    assign b_commit = b_valid_reg && ((b_mask_reg == '0) || grp_free);
    assign s_tready = !b_valid_reg || b_commit;

    // word layout: [1:0] older row, [3:2] newer row
    assign line_word = fwd_reg ? fwd_data_reg : ram_rdata;
    assign up_code   = line_word[1:0];
    assign mid_code  = line_word[3:2];
    assign wr_word   = {b_code_reg, mid_code};

    lcs_ram #(
        .WIDTH (4),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (b_commit),
        .waddr (b_c_reg),
        .wdata (wr_word),
        .re    (s_xfer),
        .raddr (cur_c),
        .rdata (ram_rdata)
    );

    // Neighbors of the center after the shift; center is the old middle right
    assign ctr_live = (win_reg[1][2] != lcs_pkg::CODE_OFF);
    assign ncount = 4'(win_reg[0][1] != lcs_pkg::CODE_OFF) +
                    4'(win_reg[0][2] != lcs_pkg::CODE_OFF) +
                    4'(up_code       != lcs_pkg::CODE_OFF) +
                    4'(win_reg[1][1] != lcs_pkg::CODE_OFF) +
                    4'(mid_code      != lcs_pkg::CODE_OFF) +
                    4'(win_reg[2][1] != lcs_pkg::CODE_OFF) +
                    4'(win_reg[2][2] != lcs_pkg::CODE_OFF) +
                    4'(b_code_reg    != lcs_pkg::CODE_OFF);

    always_comb
    begin
        v0_code = lcs_pkg::CODE_OFF;
        if (b_inner_reg &&
            ((ncount == lcs_pkg::BIRTH_COUNT) || (ctr_live && ncount == lcs_pkg::KEEP_COUNT)))
        begin
            v0_code = ctr_live ? lcs_pkg::CODE_SURVIVE : lcs_pkg::CODE_BORN;
        end
    end

    // Border results are always off, so they changed whenever the old cell was not off
    assign chg_bits = {b_code_reg    != lcs_pkg::CODE_OFF,
                       win_reg[2][2] != lcs_pkg::CODE_OFF,
                       mid_code      != lcs_pkg::CODE_OFF,
                       v0_code       != win_reg[1][2]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
        end
        else
        begin
            if (s_xfer)
            begin
                b_valid_reg <= 1'b1;
                // the entry written this cycle is the one just read
                fwd_reg     <= b_commit && (b_c_reg == cur_c);
            end
            else if (b_commit)
            begin
                b_valid_reg <= 1'b0;
                fwd_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            b_c_reg      <= cur_c;
            b_r_reg      <= cur_r;
            b_mask_reg   <= res_mask;
            b_inner_reg  <= inner;
            b_code_reg   <= cur_code;
            fwd_data_reg <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= lcs_pkg::CODE_OFF;
                end
            end
        end
        else if (b_commit)
        begin
            for (int i = 0; i < 3; i++)
            begin
                win_reg[i][0] <= win_reg[i][1];
                win_reg[i][1] <= win_reg[i][2];
            end
            win_reg[0][2] <= up_code;
            win_reg[1][2] <= mid_code;
            win_reg[2][2] <= b_code_reg;
        end
    end

    // ------------------------------------------------------------------
    // Output group: up to four results of one pixel, sent lowest first
    // ------------------------------------------------------------------
    logic [3:0]            grp_mask_reg, grp_mask_next;
    logic [3:0]            grp_chg_reg;
    lcs_pkg::cell_t        grp_v_reg;
    logic [CB-1:0]         grp_c_reg;
    logic [RB-1:0]         grp_r_reg;
    logic [3:0]            lowest;
    logic [3:0]            rest;
    logic                  m_xfer;
    logic [CB-1:0]         col_sel;
    logic [RB-1:0]         row_sel;
    logic [lcs_pkg::PIX_W-1:0] pix_sel;

    assign lowest   = grp_mask_reg & (~grp_mask_reg + 4'd1);
    assign rest     = grp_mask_reg & ~lowest;
    assign m_tvalid = (grp_mask_reg != '0);
    assign m_tlast  = (rest == '0);
    assign m_xfer   = m_tvalid && m_tready;
    assign grp_free = !m_tvalid || (m_tready && m_tlast);
    assign grp_load = b_commit && (b_mask_reg != '0);

    assign row_sel = (lowest[0] || lowest[1]) ? (grp_r_reg - RB'(1)) : grp_r_reg;
    assign col_sel = (lowest[0] || lowest[2]) ? (grp_c_reg - CB'(1)) : grp_c_reg;
    assign pix_sel = lowest[0] ? lcs_pkg::code_pixel(grp_v_reg) : lcs_pkg::PIX_OFF;

    assign m_tdata = {4'd0, pix_sel, lcs_pkg::POS_W'(col_sel), lcs_pkg::POS_W'(row_sel)};
    assign m_tuser = |(lowest & grp_chg_reg);

    always_comb
    begin
        grp_mask_next = grp_mask_reg;
        if (grp_load)
            grp_mask_next = b_mask_reg;
        else if (m_xfer)
            grp_mask_next = rest;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grp_mask_reg <= '0;
        else
            grp_mask_reg <= grp_mask_next;
    end

    always_ff @(posedge clk)
    begin
        if (grp_load)
        begin
            grp_chg_reg <= chg_bits;
            grp_v_reg   <= v0_code;
            grp_c_reg   <= b_c_reg;
            grp_r_reg   <= b_r_reg;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a stalled update stage keeps its item and memory address
    `LCS_ASSERT_NEXT(a_update_hold, clk, rst_n, b_valid_reg && !b_commit, b_valid_reg && $stable(b_c_reg))
    // forwarded data only exists for an item in the update stage
    `LCS_ASSERT_IMP(a_fwd_owned, clk, rst_n, fwd_reg, b_valid_reg)
    // the final result of a group empties the output unless a new group loads
    `LCS_ASSERT_NEXT(a_group_drain, clk, rst_n, m_xfer && m_tlast && !grp_load, !m_tvalid)

endmodule
